// ===== sv/lzos_pkg.sv =====
`timescale 1ns / 1ps
package lzos_pkg;

    localparam int SLOT_W         = 8;
    localparam int HEIGHT_W       = 9;
    localparam int NUM_LAYERS_DEF = 256;
    localparam int POOL_MAX       = 256;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_MOVE  = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    localparam logic signed [HEIGHT_W-1:0] HIDDEN = '1;

    typedef struct packed {
        logic                ot_we;
        logic [SLOT_W-1:0]   ot_waddr;
        logic [SLOT_W-1:0]   ot_wdata;
        logic [SLOT_W-1:0]   ot_raddr;
        logic                h_we;
        logic [SLOT_W-1:0]   h_waddr;
        logic [HEIGHT_W-1:0] h_wdata;
        logic [SLOT_W-1:0]   h_raddr;
    } tbl_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   ot_rdata;
        logic [HEIGHT_W-1:0] h_rdata;
    } tbl_rsp_t;

endpackage

// ===== sv/lzos_tables.sv =====
`timescale 1ns / 1ps
module lzos_tables #(
    parameter int NUM_LAYERS = lzos_pkg::NUM_LAYERS_DEF
) (
    input  logic               clk,
    input  lzos_pkg::tbl_req_t req,
    output lzos_pkg::tbl_rsp_t rsp
);
    import lzos_pkg::*;

    localparam int POOL = (NUM_LAYERS < POOL_MAX) ? NUM_LAYERS : POOL_MAX;
    localparam int AW   = $clog2(POOL);

    logic [SLOT_W-1:0]   order_mem  [POOL];
    logic [HEIGHT_W-1:0] height_mem [POOL];
    logic [SLOT_W-1:0]   ot_rdata_reg;
    logic [HEIGHT_W-1:0] h_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.ot_we)
        begin
            order_mem[req.ot_waddr[AW-1:0]] <= req.ot_wdata;
        end
        ot_rdata_reg <= order_mem[req.ot_raddr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req.h_we)
        begin
            height_mem[req.h_waddr[AW-1:0]] <= req.h_wdata;
        end
        h_rdata_reg <= height_mem[req.h_raddr[AW-1:0]];
    end

    assign rsp.ot_rdata = ot_rdata_reg;
    assign rsp.h_rdata  = h_rdata_reg;

endmodule

// ===== sv/layer_z_order_stack_core.sv =====
`timescale 1ns / 1ps
// channel | signals                                      | item accepted when
// --------+----------------------------------------------+-------------------------
// input   | in_valid, in_stall, func, layer_id,          | in_valid && !in_stall
//         | req_height                                   |
// output  | out_valid, out_stall, status, result_layer,  | out_valid && !out_stall
//         | result_height, stack_top                     |
//
// One item at a time. Allocate scans the in-use bits one slot per cycle.
// Move and free read the stored height, then shift the layers in between (up to POOL-1),
// each with one read and one write on the order-table port. A slot not in use goes straight
// to the result; an unknown operation code on a slot in use returns the stored height.
// Reset clears the in-use bits, the top height and control; the memories are not cleared.
// A new item is taken while the previous result waits on a stalled output.
module layer_z_order_stack_core #(
    parameter int NUM_LAYERS = lzos_pkg::NUM_LAYERS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             func,
    input  logic [lzos_pkg::SLOT_W-1:0]            layer_id,
    input  logic signed [lzos_pkg::HEIGHT_W-1:0]   req_height,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   status,
    output logic [lzos_pkg::SLOT_W-1:0]            result_layer,
    output logic signed [lzos_pkg::HEIGHT_W-1:0]   result_height,
    output logic signed [lzos_pkg::HEIGHT_W-1:0]   stack_top
);
    import lzos_pkg::*;

    localparam int POOL = (NUM_LAYERS < POOL_MAX) ? NUM_LAYERS : POOL_MAX;
    localparam int AW   = $clog2(POOL);
    localparam int XW   = HEIGHT_W + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_HRD  = 8'b0000_0100,
        S_PLAN = 8'b0000_1000,
        S_SRD  = 8'b0001_0000,
        S_SWR  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [HEIGHT_W-1:0] top_reg, top_next;
    logic [POOL-1:0]            in_use_reg, in_use_next;
    logic                       out_valid_reg, out_valid_next;

    logic [1:0]                 func_reg, func_next;
    logic [SLOT_W-1:0]          id_reg, id_next;
    logic signed [HEIGHT_W-1:0] req_reg, req_next;
    logic [AW-1:0]              scan_reg, scan_next;
    logic [AW-1:0]              dst_reg, dst_next;
    logic [AW:0]                cnt_reg, cnt_next;
    logic                       up_reg, up_next;
    logic signed [HEIGHT_W-1:0] want_reg, want_next;
    logic                       wr_ot_reg, wr_ot_next;
    logic                       top_inc_reg, top_inc_next;
    logic                       top_dec_reg, top_dec_next;
    logic                       res_status_reg, res_status_next;
    logic [SLOT_W-1:0]          res_layer_reg, res_layer_next;
    logic signed [HEIGHT_W-1:0] res_height_reg, res_height_next;
    logic                       out_status_reg, out_status_next;
    logic [SLOT_W-1:0]          out_layer_reg, out_layer_next;
    logic signed [HEIGHT_W-1:0] out_height_reg, out_height_next;
    logic signed [HEIGHT_W-1:0] out_top_reg, out_top_next;

    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;

    logic                 in_accept;
    logic                 id_ok;
    logic                 out_free;
    logic signed [XW-1:0] old_x, top_x, req_x, limit_x, want_x, start_x, count_x;
    logic                 old_vis, want_vis, go_up;

    lzos_tables #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_tables (
        .clk (clk),
        .req (tbl_req),
        .rsp (tbl_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign id_ok     = ((SLOT_W + 1)'(layer_id) < (SLOT_W + 1)'(POOL))
                       && in_use_reg[layer_id[AW-1:0]];
    assign out_free  = !out_valid_reg || !out_stall;

    // plan the move from the stored height
    always_comb
    begin
        old_x    = {tbl_rsp.h_rdata[HEIGHT_W-1], tbl_rsp.h_rdata};
        top_x    = {top_reg[HEIGHT_W-1], top_reg};
        req_x    = {req_reg[HEIGHT_W-1], req_reg};
        old_vis  = !old_x[XW-1];
        limit_x  = old_vis ? top_x : top_x + XW'(1);
        if (func_reg == FUNC_FREE)
        begin
            want_x = -XW'(1);
        end
        else
        begin
            want_x = (req_x > limit_x) ? limit_x : req_x;
            if (want_x < -XW'(1))
            begin
                want_x = -XW'(1);
            end
        end
        want_vis = !want_x[XW-1];
        go_up    = want_vis && (!old_vis || (want_x < old_x));
        start_x  = go_up ? (old_vis ? old_x : top_x + XW'(1)) : old_x;
        count_x  = go_up ? (start_x - want_x) : ((want_vis ? want_x : top_x) - old_x);
    end

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        in_use_next     = in_use_reg;
        out_valid_next  = out_valid_reg && out_stall;
        func_next       = func_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        scan_next       = scan_reg;
        dst_next        = dst_reg;
        cnt_next        = cnt_reg;
        up_next         = up_reg;
        want_next       = want_reg;
        wr_ot_next      = wr_ot_reg;
        top_inc_next    = top_inc_reg;
        top_dec_next    = top_dec_reg;
        res_status_next = res_status_reg;
        res_layer_next  = res_layer_reg;
        res_height_next = res_height_reg;
        out_status_next = out_status_reg;
        out_layer_next  = out_layer_reg;
        out_height_next = out_height_reg;
        out_top_next    = out_top_reg;
        tbl_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = func;
                    id_next         = layer_id;
                    req_next        = req_height;
                    scan_next       = '0;
                    res_status_next = (func == FUNC_ALLOC);
                    res_layer_next  = (func == FUNC_ALLOC) ? '0 : layer_id;
                    res_height_next = HIDDEN;
                    if (func == FUNC_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (id_ok)
                    begin
                        state_next = S_HRD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!in_use_reg[scan_reg])
                begin
                    in_use_next[scan_reg] = 1'b1;
                    tbl_req.h_we          = 1'b1;
                    tbl_req.h_waddr       = SLOT_W'(scan_reg);
                    tbl_req.h_wdata       = HIDDEN;
                    res_status_next       = 1'b0;
                    res_layer_next        = SLOT_W'(scan_reg);
                    state_next            = S_DONE;
                end
                else if (scan_reg == AW'(POOL - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            S_HRD:
            begin
                tbl_req.h_raddr = id_reg;
                state_next      = S_PLAN;
            end
            S_PLAN:
            begin
                if ((func_reg == FUNC_MOVE) || (func_reg == FUNC_FREE))
                begin
                    want_next    = want_x[HEIGHT_W-1:0];
                    up_next      = go_up;
                    dst_next     = start_x[AW-1:0];
                    cnt_next     = count_x[AW:0];
                    if (want_x == old_x)
                    begin
                        wr_ot_next   = 1'b0;
                        top_inc_next = 1'b0;
                        top_dec_next = 1'b0;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        wr_ot_next   = want_vis;
                        top_inc_next = !old_vis;
                        top_dec_next = old_vis && !want_vis;
                        state_next   = (count_x == '0) ? S_FIN : S_SRD;
                    end
                end
                else
                begin
                    res_height_next = tbl_rsp.h_rdata;
                    state_next      = S_DONE;
                end
            end
            S_SRD:
            begin
                tbl_req.ot_raddr = SLOT_W'(up_reg ? dst_reg - AW'(1) : dst_reg + AW'(1));
                state_next       = S_SWR;
            end
            S_SWR:
            begin
                tbl_req.ot_we    = 1'b1;
                tbl_req.ot_waddr = SLOT_W'(dst_reg);
                tbl_req.ot_wdata = tbl_rsp.ot_rdata;
                tbl_req.h_we     = 1'b1;
                tbl_req.h_waddr  = tbl_rsp.ot_rdata;
                tbl_req.h_wdata  = HEIGHT_W'(dst_reg);
                dst_next         = up_reg ? dst_reg - AW'(1) : dst_reg + AW'(1);
                cnt_next         = cnt_reg - (AW + 1)'(1);
                state_next       = (cnt_reg == (AW + 1)'(1)) ? S_FIN : S_SRD;
            end
            S_FIN:
            begin
                tbl_req.h_we     = 1'b1;
                tbl_req.h_waddr  = id_reg;
                tbl_req.h_wdata  = want_reg;
                tbl_req.ot_we    = wr_ot_reg;
                tbl_req.ot_waddr = SLOT_W'(want_reg[AW-1:0]);
                tbl_req.ot_wdata = id_reg;
                if (top_inc_reg)
                begin
                    top_next = top_reg + HEIGHT_W'(1);
                end
                else if (top_dec_reg)
                begin
                    top_next = top_reg - HEIGHT_W'(1);
                end
                if (func_reg == FUNC_FREE)
                begin
                    in_use_next[id_reg[AW-1:0]] = 1'b0;
                end
                res_height_next = want_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_layer_next  = res_layer_reg;
                    out_height_next = res_height_reg;
                    out_top_next    = top_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= HIDDEN;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        id_reg         <= id_next;
        req_reg        <= req_next;
        scan_reg       <= scan_next;
        dst_reg        <= dst_next;
        cnt_reg        <= cnt_next;
        up_reg         <= up_next;
        want_reg       <= want_next;
        wr_ot_reg      <= wr_ot_next;
        top_inc_reg    <= top_inc_next;
        top_dec_reg    <= top_dec_next;
        res_status_reg <= res_status_next;
        res_layer_reg  <= res_layer_next;
        res_height_reg <= res_height_next;
        out_status_reg <= out_status_next;
        out_layer_reg  <= out_layer_next;
        out_height_reg <= out_height_next;
        out_top_reg    <= out_top_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_layer  = out_layer_reg;
    assign result_height = out_height_reg;
    assign stack_top     = out_top_reg;

endmodule

// ===== sv/lzos_checker.sv =====
`timescale 1ns / 1ps
module lzos_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic [1:0]                             func,
    input logic [lzos_pkg::SLOT_W-1:0]            layer_id,
    input logic signed [lzos_pkg::HEIGHT_W-1:0]   req_height,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic                                   status,
    input logic [lzos_pkg::SLOT_W-1:0]            result_layer,
    input logic signed [lzos_pkg::HEIGHT_W-1:0]   result_height,
    input logic signed [lzos_pkg::HEIGHT_W-1:0]   stack_top
);
    import lzos_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_height) && $stable(stack_top))
        else $error("stalled result dropped or changed");

    a_full_pool: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> result_layer == '0 && result_height == HIDDEN)
        else $error("failed allocate reports a layer");

    a_height_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_height != HIDDEN) |-> !result_height[HEIGHT_W-1]
        && (result_height <= stack_top))
        else $error("visible layer above stack top");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stack_top >= HIDDEN)
        else $error("stack top below hidden");

endmodule

bind layer_z_order_stack_core lzos_checker u_lzos_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import lzos_pkg::*;

    localparam int NUM_LAYERS     = NUM_LAYERS_DEF;
    localparam int POOL           = (NUM_LAYERS < POOL_MAX) ? NUM_LAYERS : POOL_MAX;
    localparam int Z_HIDDEN       = HIDDEN;
    localparam int MAX_HEIGHT     = (1 << (HEIGHT_W - 1)) - 1;
    localparam int RANDOM_ITEMS   = 590;
    localparam int SCRAMBLE_MOVES = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 600;
    localparam int MAX_PRINTS     = 200;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic       ST_DONE     = 1'b0;
    localparam logic       ST_FULL     = 1'b1;

    typedef struct packed {
        logic                       status;
        logic [SLOT_W-1:0]          layer;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [HEIGHT_W-1:0] top;
    } z_result_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_stall;
    logic [1:0]                 func          = FUNC_ALLOC;
    logic [SLOT_W-1:0]          layer_id      = '0;
    logic signed [HEIGHT_W-1:0] req_height    = '0;
    logic                       out_valid;
    logic                       out_stall     = 1'b0;
    logic                       status;
    logic [SLOT_W-1:0]          result_layer;
    logic signed [HEIGHT_W-1:0] result_height;
    logic signed [HEIGHT_W-1:0] stack_top;

    logic [SLOT_W-1:0] z_slot_at [POOL];
    int                z_height_of [POOL];
    bit                z_busy [POOL];
    int                z_top = Z_HIDDEN;

    z_result_t pending_results [$];
    int        n_errors     = 0;
    bit        no_gaps      = 1'b0;
    int        stall_left   = 0;
    int        quiet_cycles = 0;

    layer_z_order_stack_core #(
        .NUM_LAYERS (NUM_LAYERS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .layer_id      (layer_id),
        .req_height    (req_height),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_layer  (result_layer),
        .result_height (result_height),
        .stack_top     (stack_top)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < POOL; i++)
        begin
            z_slot_at[i]   = '0;
            z_height_of[i] = Z_HIDDEN;
            z_busy[i]      = 1'b0;
        end
    end

    function automatic int idle_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // shift the layers between the old and the new height, keep the stack dense
    task automatic restack(input int id, input int want);
        int old;
        int lim;
        int k;
        old = z_height_of[id];
        lim = (old >= 0) ? z_top : z_top + 1;
        if (want > lim)
            want = lim;
        if (want < Z_HIDDEN)
            want = Z_HIDDEN;
        if (old > want)
        begin
            if (want >= 0)
            begin
                for (k = old; k > want; k--)
                begin
                    z_slot_at[k] = z_slot_at[k - 1];
                    z_height_of[z_slot_at[k]] = k;
                end
                z_slot_at[want] = 8'(id);
            end
            else
            begin
                for (k = old; k < z_top; k++)
                begin
                    z_slot_at[k] = z_slot_at[k + 1];
                    z_height_of[z_slot_at[k]] = k;
                end
                z_top--;
            end
        end
        else if (old < want)
        begin
            if (old >= 0)
            begin
                for (k = old; k < want; k++)
                begin
                    z_slot_at[k] = z_slot_at[k + 1];
                    z_height_of[z_slot_at[k]] = k;
                end
                z_slot_at[want] = 8'(id);
            end
            else
            begin
                for (k = z_top; k >= want; k--)
                begin
                    z_slot_at[k + 1] = z_slot_at[k];
                    z_height_of[z_slot_at[k + 1]] = k + 1;
                end
                z_slot_at[want] = 8'(id);
                z_top++;
            end
        end
        z_height_of[id] = want;
    endtask

    task automatic predict_layer_op(input logic [1:0] f, input logic [SLOT_W-1:0] id,
                                    input logic signed [HEIGHT_W-1:0] req);
        z_result_t r;
        bit        live;
        bit        hit;
        int        i;
        live     = (int'(id) < POOL) && z_busy[id];
        r.status = ST_DONE;
        r.layer  = id;
        r.height = HIDDEN;
        case (f)
            FUNC_ALLOC:
            begin
                r.layer  = '0;
                r.status = ST_FULL;
                hit      = 1'b0;
                for (i = 0; i < POOL && !hit; i++)
                begin
                    if (!z_busy[i])
                    begin
                        z_busy[i]      = 1'b1;
                        z_height_of[i] = Z_HIDDEN;
                        r.layer        = 8'(i);
                        r.status       = ST_DONE;
                        hit            = 1'b1;
                    end
                end
            end
            FUNC_MOVE:
            begin
                if (live)
                begin
                    restack(id, int'(req));
                    r.height = 9'(z_height_of[id]);
                end
            end
            FUNC_FREE:
            begin
                if (live)
                begin
                    if (z_height_of[id] >= 0)
                        restack(id, Z_HIDDEN);
                    z_busy[id] = 1'b0;
                end
            end
            default:
            begin
                if (live)
                    r.height = 9'(z_height_of[id]);
            end
        endcase
        r.top = 9'(z_top);
        pending_results.push_back(r);
    endtask

    task automatic send_item(input logic [1:0] f, input logic [SLOT_W-1:0] id,
                             input logic signed [HEIGHT_W-1:0] h);
        int gap;
        bit taken;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        layer_id   <= id;
        req_height <= h;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        predict_layer_op(f, id, h);
    endtask

    // hold the sender until every pending result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_live();
        int ids [$];
        int i;
        for (i = 0; i < POOL; i++)
            if (z_busy[i])
                ids.push_back(i);
        if (ids.size() == 0)
            return -1;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function automatic int count_live();
        int n;
        int i;
        n = 0;
        for (i = 0; i < POOL; i++)
            n += int'(z_busy[i]);
        return n;
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        int v;
        case ($urandom_range(0, 9))
            0:       v = Z_HIDDEN;
            1:       v = -int'($urandom_range(2, MAX_HEIGHT + 1));
            2:       v = 0;
            3:       v = z_top;
            4:       v = z_top + 1;
            5:       v = MAX_HEIGHT;
            default: v = $urandom_range(0, z_top + 2);
        endcase
        if (v > MAX_HEIGHT)
            v = MAX_HEIGHT;
        return 9'(v);
    endfunction

    task automatic test_directed();
        send_item(FUNC_ALLOC, 8'd255, 255);
        send_item(FUNC_ALLOC, 8'd0, -256);
        send_item(FUNC_ALLOC, 8'd0, 0);
        send_item(FUNC_MOVE, 8'd0, 255);
        send_item(FUNC_MOVE, 8'd1, 0);
        send_item(FUNC_MOVE, 8'd2, -2);
        send_item(FUNC_MOVE, 8'd2, 1);
        send_item(FUNC_MOVE, 8'd2, 255);
        send_item(FUNC_MOVE, 8'd1, 255);
        send_item(FUNC_MOVE, 8'd2, 0);
        send_item(FUNC_MOVE, 8'd0, -256);
        send_item(FUNC_MOVE, 8'd0, -1);
        send_item(FUNC_MOVE, 8'd0, 0);
        send_item(FUNC_UNUSED, 8'd2, 7);
        send_item(FUNC_UNUSED, 8'd200, -1);
        send_item(FUNC_MOVE, 8'd77, 3);
        send_item(FUNC_FREE, 8'd77, 0);
        send_item(FUNC_MOVE, 8'd1, 1);
        send_item(FUNC_FREE, 8'd1, 0);
        send_item(FUNC_ALLOC, 8'd170, 85);
        send_item(FUNC_FREE, 8'd1, 0);
        send_item(FUNC_FREE, 8'd1, 0);
        send_item(FUNC_FREE, 8'd255, -256);
        send_item(FUNC_MOVE, 8'd255, 255);
        drain_results();
    endtask

    task automatic test_pool_exhaust();
        int order [$];
        int i;
        int j;
        int tmp;
        for (i = 0; i < POOL + 2; i++)
            send_item(FUNC_ALLOC, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
        drain_results();
        for (i = 0; i < SCRAMBLE_MOVES; i++)
            send_item(FUNC_MOVE, 8'(pick_live()), pick_height());
        for (i = 0; i < POOL; i++)
            if (z_busy[i])
                order.push_back(i);
        for (i = order.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_item(FUNC_FREE, 8'(order[i]), 9'($urandom_range(0, 511)));
        drain_results();
    endtask

    task automatic test_random_ops();
        int n;
        int r;
        int live;
        int id;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                no_gaps = ($urandom_range(0, 4) == 0);
            r    = $urandom_range(0, 99);
            live = count_live();
            id   = pick_live();
            if (id < 0 || r < 14 || (live < 24 && r < 40))
                send_item(FUNC_ALLOC, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
            else if (r < 62)
                send_item(FUNC_MOVE, 8'(id), pick_height());
            else if (r < 74)
                send_item(FUNC_FREE, 8'(id), 9'($urandom_range(0, 511)));
            else if (r < 80)
                send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
            else
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 511)));
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    always @(negedge clk)
    begin
        z_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result, layer %0d", result_layer));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %b, want %b", status, want.status));
                if (result_layer !== want.layer)
                    flag_error($sformatf("result_layer %0d, want %0d",
                                         result_layer, want.layer));
                if (result_height !== want.height)
                    flag_error($sformatf("result_height %0d, want %0d",
                                         result_height, want.height));
                if (stack_top !== want.top)
                    flag_error($sformatf("stack_top %0d, want %0d", stack_top, want.top));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pool_exhaust();
        test_random_ops();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
